FILE: rtl/sib_pkg.sv
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types and constants for the sorted index insert builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sib_pkg;

	localparam int KEY_W             = 32;
	localparam int POS_W             = 5;
	localparam int TABLE_DEPTH_DEF   = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic signed [KEY_W-1:0] record_key;
	} cmd_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] entry_key;
		logic [POS_W-1:0]        entry_position;
		logic                    entry_valid;
		logic                    last_entry;
		logic                    overflowed;
	} ent_req_t;

	// per-cell control from the chain controller
	typedef struct packed {
		logic ins_en;    // an insert is applied this cycle
		logic shift_en;  // drain: every cell takes its right neighbor
		logic occupied;  // cell index is below the entry count
		logic tail;      // cell index equals the entry count
	} cell_ctl_t;

endpackage

FILE: rtl/sib_cell.sv
// ----------------------------------------------------------------------------
// sib_cell
// One compare-and-shift cell of the sorted chain: holds a key and its arrival
// position, moves right on insert and left on drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sib_cell (
	input  logic                             clk,
	input  sib_pkg::cell_ctl_t               ctl,
	input  logic signed [sib_pkg::KEY_W-1:0] new_key,
	input  logic [sib_pkg::POS_W-1:0]        new_pos,
	input  logic signed [sib_pkg::KEY_W-1:0] left_key,
	input  logic [sib_pkg::POS_W-1:0]        left_pos,
	input  logic                             left_gt,
	input  logic signed [sib_pkg::KEY_W-1:0] right_key,
	input  logic [sib_pkg::POS_W-1:0]        right_pos,
	output logic signed [sib_pkg::KEY_W-1:0] key,
	output logic [sib_pkg::POS_W-1:0]        pos,
	output logic                             gt
);
	import sib_pkg::*;

	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        pos_q;

	// strictly greater: equal keys stay ahead of the new one
	assign gt  = ctl.occupied && (key_q > new_key);
	assign key = key_q;
	assign pos = pos_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			key_q <= right_key;
			pos_q <= right_pos;
		end else if (ctl.ins_en && (gt || ctl.tail)) begin
			// first displaced cell takes the new key, the rest take the left one
			if (left_gt) begin
				key_q <= left_key;
				pos_q <= left_pos;
			end else begin
				key_q <= new_key;
				pos_q <= new_pos;
			end
		end
	end

endmodule

FILE: rtl/sorted_index_insert_builder.sv
// ----------------------------------------------------------------------------
// sorted_index_insert_builder
// Keeps up to TABLE_DEPTH keys sorted in ascending order in a chain of
// compare-and-shift cells, each key paired with its arrival number. On an
// insert request every cell compares the broadcast key with its own and the
// cells holding larger keys shift one place right, so equal keys keep
// arrival order. An insert into a full table is dropped and sets a sticky
// overflow flag. A flush request drains the chain from cell 0, one entry per
// cycle that the output register is free; an empty flush gives a single
// invalid entry. cmd_stall stays high until the last entry is loaded into
// the output register. The flush clears the table and the overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_index_insert_builder #(
	parameter int TABLE_DEPTH = sib_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  sib_pkg::cmd_req_t cmd,
	output logic              ent_valid,
	input  logic              ent_stall,
	output sib_pkg::ent_req_t ent
);
	import sib_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             empty_q;
	logic             ent_vld_q;
	ent_req_t         ent_q;

	logic cmd_go;
	logic ins_go;
	logic slot_free;
	logic emit;

	logic signed [KEY_W-1:0] cell_key [TABLE_DEPTH];
	logic [POS_W-1:0]        cell_pos [TABLE_DEPTH];
	logic                    cell_gt  [TABLE_DEPTH];

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_go    = cmd_valid && !cmd_stall;
	assign ins_go    = cmd_go && (cmd.mode == MODE_INSERT) && (count_q != FULL_CNT);
	assign slot_free = !ent_vld_q || !ent_stall;
	assign emit      = (state_q == ST_DRAIN) && slot_free;

	assign ent_valid = ent_vld_q;
	assign ent       = ent_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		cell_ctl_t               ctl;
		logic signed [KEY_W-1:0] l_key;
		logic [POS_W-1:0]        l_pos;
		logic                    l_gt;
		logic signed [KEY_W-1:0] r_key;
		logic [POS_W-1:0]        r_pos;

		assign ctl.ins_en   = ins_go;
		assign ctl.shift_en = emit && !empty_q;
		assign ctl.occupied = (IDX < count_q);
		assign ctl.tail     = (IDX == count_q);

		if (i == 0) begin : g_first
			assign l_key = '0;
			assign l_pos = '0;
			assign l_gt  = 1'b0;
		end else begin : g_mid
			assign l_key = cell_key[i-1];
			assign l_pos = cell_pos[i-1];
			assign l_gt  = cell_gt[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign r_key = cell_key[i];
			assign r_pos = cell_pos[i];
		end else begin : g_inner
			assign r_key = cell_key[i+1];
			assign r_pos = cell_pos[i+1];
		end

		sib_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_key   (cmd.record_key),
			.new_pos   (POS_W'(count_q)),
			.left_key  (l_key),
			.left_pos  (l_pos),
			.left_gt   (l_gt),
			.right_key (r_key),
			.right_pos (r_pos),
			.key       (cell_key[i]),
			.pos       (cell_pos[i]),
			.gt        (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			empty_q   <= 1'b0;
			ent_vld_q <= 1'b0;
			ent_q     <= '0;
		end else begin
			if (ent_vld_q && !ent_stall && !emit) begin
				ent_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_go) begin
						if (cmd.mode == MODE_FLUSH) begin
							state_q <= ST_DRAIN;
							empty_q <= (count_q == '0);
						end else if (count_q == FULL_CNT) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + ONE_CNT;
						end
					end
				end
				ST_DRAIN: begin
					if (slot_free) begin
						ent_vld_q            <= 1'b1;
						ent_q.entry_key      <= empty_q ? '0 : cell_key[0];
						ent_q.entry_position <= empty_q ? '0 : cell_pos[0];
						ent_q.entry_valid    <= !empty_q;
						ent_q.last_entry     <= empty_q || (count_q == ONE_CNT);
						ent_q.overflowed     <= ovf_q;
						if (!empty_q) begin
							count_q <= count_q - ONE_CNT;
						end
						if (empty_q || (count_q == ONE_CNT)) begin
							state_q <= ST_IDLE;
							ovf_q   <= 1'b0;
							empty_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above table depth");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
		else $error("chain head out of order");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> (count_q == $past(count_q) + ONE_CNT))
		else $error("insert did not grow the table");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_go && (cmd.mode == MODE_INSERT) && (count_q == FULL_CNT)) |=> ovf_q)
		else $error("dropped insert did not set overflow");

	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_vld_q && !ent_q.entry_valid) |-> ent_q.last_entry)
		else $error("empty flush entry not marked last");
`endif

endmodule
